FILE: hdl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with asynchronous active-low reset masking.
`define CFD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Same check on the house clock and reset names.
`define CFD_ASSERT(lbl, prop, msg) `CFD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: hdl/cfd_pkg.sv
// Shared types and constants for the CRC-16 framed packet deframer.
// No dependencies.
`default_nettype none
package cfd_pkg;

  localparam logic [7:0]  HdrByte    = 8'hAA;
  localparam logic [7:0]  TailByte   = 8'h55;
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'hA001;
  localparam logic [15:0] MaxPayload = 16'd128;

  localparam int unsigned ResDataW = 48;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_CRC_ERR  = 2'd1,
    STAT_BAD_TAIL = 2'd2,
    STAT_TOO_LONG = 2'd3
  } frame_status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } result_kind_e;

  typedef struct packed {
    result_kind_e  result_kind;
    logic [7:0]    payload_byte;
    logic [6:0]    byte_index;
    logic [7:0]    frame_type;
    logic [15:0]   frame_length;
    frame_status_e frame_status;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/crc16_framed_packet_deframer.sv
// Top level of the CRC-16 framed packet deframer: input register, parser,
// result register. Depends on cfd_pkg, cfd_parser and assert_macros.svh.
//
// Usage:
//   s_axis carries one received serial byte per item (tdata[7:0]).
//   m_axis carries results: tuser marks a tentative payload byte (0) or an
//   end-of-frame verdict (1); tdata holds the byte, its index and the
//   frame's type, length and status.
//   Frames: 0xAA, type, length (big endian), payload, CRC (big endian), 0x55.
//   Path: a byte accepted into the input register is parsed from there, and
//   its result, if any, is written to the result register.
//   Throughput: one byte per cycle while no stall holds, set by the combinational
//   byte CRC update and phase machine between the two registers.
//   Reset: parser waits for a header, both registers empty.
//   Stall: while a result waits, the input register still drains bytes
//   that give no result; a byte that gives a result waits in the input
//   register and s_axis_tready_o drops until the result is taken.
`default_nettype none
`include "assert_macros.svh"
module crc16_framed_packet_deframer import cfd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [7:0] in_byte
  input  wire logic [7:0]          s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [7:0] payload_byte, [14:8] byte_index, [22:15] frame_type,
  // [38:23] frame_length, [40:39] frame_status, [47:41] zero
  output logic [ResDataW-1:0]      m_axis_tdata_o,
  // [0] result_kind
  output logic                     m_axis_tuser_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       res_valid;
  result_t    res;
  logic       out_valid_q;
  result_t    out_q;
  logic       out_free;
  logic       step;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && (!res_valid || out_free);
  assign s_axis_tready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  cfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.result_kind;
  assign m_axis_tdata_o  = {7'd0, out_q.frame_status, out_q.frame_length,
                            out_q.frame_type, out_q.byte_index, out_q.payload_byte};

  `CFD_ASSERT(a_verdict_clean, (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[14:0] == 15'd0), "verdict carries payload bits")
  `CFD_ASSERT(a_payload_status, (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[40:39] == 2'd0), "payload item carries a status")
  `CFD_ASSERT(a_stall_cause, !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i), "input stalled without a waiting result")
  `CFD_ASSERT(a_no_overwrite, (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(out_q)), "waiting result overwritten")

endmodule
`default_nettype wire

FILE: hdl/cfd_crc.sv
// Byte-wide CRC-16/MODBUS update (reflected, polynomial 0xA001).
// Depends on cfd_pkg.
`default_nettype none
module cfd_crc import cfd_pkg::*; (
  input  wire logic [15:0] crc_i,
  input  wire logic [7:0]  byte_i,
  output logic      [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, byte_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule
`default_nettype wire

FILE: hdl/cfd_parser.sv
// Frame phase machine: holds header fields, running CRC and payload count,
// and forms at most one result per byte. Depends on cfd_pkg and cfd_crc.
`default_nettype none
module cfd_parser import cfd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_TYPE     = 3'd1,
    PH_LEN_HI   = 3'd2,
    PH_LEN_LO   = 3'd3,
    PH_PAYLOAD  = 3'd4,
    PH_CRC_HI   = 3'd5,
    PH_CRC_LO   = 3'd6,
    PH_TAIL     = 3'd7
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] rx_crc_q, rx_crc_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_next;
  logic [15:0] cnt_inc;

  cfd_crc u_crc (
    .crc_i  (crc_q),
    .byte_i (byte_i),
    .crc_o  (crc_next)
  );

  assign cnt_inc = cnt_q + 16'd1;

  always_comb begin
    phase_d     = phase_q;
    type_d      = type_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    rx_crc_d    = rx_crc_q;
    crc_d       = crc_q;
    res_valid_o = 1'b0;
    res_o.result_kind  = KIND_PAYLOAD;
    res_o.payload_byte = 8'h00;
    res_o.byte_index   = 7'd0;
    res_o.frame_type   = type_q;
    res_o.frame_length = len_q;
    res_o.frame_status = STAT_OK;
    unique case (phase_q)
      PH_HEADER: begin
        if (byte_i == HdrByte) begin
          crc_d   = CrcInit;
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_d  = byte_i;
        crc_d   = crc_next;
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_d   = {byte_i, 8'h00};
        crc_d   = crc_next;
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d   = {len_q[15:8], byte_i};
        crc_d   = crc_next;
        cnt_d   = 16'd0;
        phase_d = ({len_q[15:8], byte_i} != 16'd0) ? PH_PAYLOAD : PH_CRC_HI;
      end
      PH_PAYLOAD: begin
        crc_d = crc_next;
        cnt_d = cnt_inc;
        if (cnt_inc >= len_q) begin
          phase_d = PH_CRC_HI;
        end
        if (cnt_q < MaxPayload) begin
          res_valid_o        = 1'b1;
          res_o.payload_byte = byte_i;
          res_o.byte_index   = cnt_q[6:0];
        end
      end
      PH_CRC_HI: begin
        rx_crc_d = {byte_i, 8'h00};
        phase_d  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        rx_crc_d = {rx_crc_q[15:8], byte_i};
        phase_d  = PH_TAIL;
      end
      PH_TAIL: begin
        res_valid_o       = 1'b1;
        res_o.result_kind = KIND_VERDICT;
        priority if (byte_i != TailByte) begin
          res_o.frame_status = STAT_BAD_TAIL;
        end else if (len_q > MaxPayload) begin
          res_o.frame_status = STAT_TOO_LONG;
        end else if (crc_q != rx_crc_q) begin
          res_o.frame_status = STAT_CRC_ERR;
        end else begin
          res_o.frame_status = STAT_OK;
        end
        phase_d = PH_HEADER;
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      type_q   <= 8'h00;
      len_q    <= 16'h0000;
      cnt_q    <= 16'h0000;
      rx_crc_q <= 16'h0000;
      crc_q    <= CrcInit;
    end else if (step_i) begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      len_q    <= len_d;
      cnt_q    <= cnt_d;
      rx_crc_q <= rx_crc_d;
      crc_q    <= crc_d;
    end
  end

endmodule
`default_nettype wire
